// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// pre holds -> post holds in the same cycle
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// pre holds -> post holds in the following cycle
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// File: rtl/crcc_pkg.sv
package crcc_pkg;

   localparam int GEN_MAX_LEN_DEF = 16;
   localparam int BYTE_BITS       = 8;
   localparam int MAX_RES         = 3;
   localparam int RES_CNT_W       = $clog2(MAX_RES + 1);
   localparam int CNT_W           = 32;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int GEN_BITS_W = 16;
   localparam int GEN_LEN_W  = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_GEN_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GEN_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DW_EIGHT = 2'd2;

   localparam logic [GEN_BITS_W-1:0] GEN_BITS_RST = 16'd13;
   localparam logic [GEN_LEN_W-1:0]  GEN_LEN_RST  = 5'd4;
   localparam logic                  DW_EIGHT_RST = 1'b0;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_COUNTS = 1'b1;

   typedef enum logic {
      PH_HEADER,
      PH_BODY
   } crcc_phase_type;

   typedef struct packed {
      logic [GEN_BITS_W-1:0] gen_bits;
      logic [GEN_LEN_W-1:0]  gen_len;
      logic                  dw_eight;
   } crcc_cfg_type;

   typedef struct packed {
      logic                 kind;
      logic [BYTE_BITS-1:0] data;
      logic [CNT_W-1:0]     cw_count;
      logic [CNT_W-1:0]     err_count;
      logic                 last;
   } crcc_res_type;

endpackage

// File: rtl/crcc_if.sv
interface crcc_req_if import crcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] in_byte;
   logic                 in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface crcc_rsp_if import crcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 out_kind;
   logic [BYTE_BITS-1:0] out_byte;
   logic [CNT_W-1:0]     codeword_count;
   logic [CNT_W-1:0]     error_count;
   logic                 out_last;

   modport source (output valid, output out_kind, output out_byte, output codeword_count,
                   output error_count, output out_last, input ready);
   modport sink   (input valid, input out_kind, input out_byte, input codeword_count,
                   input error_count, input out_last, output ready);
endinterface

interface crcc_csr_if import crcc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/crcc_engine.sv
`include "assert_macros.svh"

module crcc_engine import crcc_pkg::*; #(
   parameter int GEN_MAX_LEN = GEN_MAX_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  crcc_cfg_type                  cfg,
   input  logic                          advance,
   input  logic [BYTE_BITS-1:0]          in_byte,
   input  logic                          in_last,
   output logic [RES_CNT_W-1:0]          res_count,
   output crcc_res_type [MAX_RES-1:0]    res
);

   localparam int IdxW = (GEN_MAX_LEN > 2) ? $clog2(GEN_MAX_LEN) : 1;
   localparam int RemW = GEN_MAX_LEN - 1;
   localparam int BicW = $clog2(BYTE_BITS + GEN_MAX_LEN);
   localparam logic [5:0] GenMax6 = 6'(GEN_MAX_LEN);

   crcc_phase_type       phase_ff, phase_in;
   logic [2:0]           skip_ff, skip_in;
   logic [BicW-1:0]      bic_ff, bic_in;
   logic [RemW-1:0]      rem_ff, rem_in;
   logic [7:0]           pend_ff, pend_in;
   logic [7:0]           acc_ff, acc_in;
   logic [2:0]           fill_ff, fill_in;
   logic [CNT_W-1:0]     cw_total_ff, cw_total_in;
   logic [CNT_W-1:0]     err_total_ff, err_total_in;

   // config decode
   logic [5:0]             len6, r6;
   logic [IdxW-1:0]        ridx;
   logic [3:0]             dsize;
   logic [BicW-1:0]        cwlen;
   logic [47:0]            gen48;
   logic [GEN_MAX_LEN-1:0] lmask, gmask;
   logic [RemW-1:0]        rmask;

   // per-byte working values
   logic                   bit_v;
   logic [GEN_MAX_LEN-1:0] t_v;
   logic [15:0]            comb16;
   logic [3:0]             nfill;
   logic [1:0]             ncw, nerr;
   logic                   dv;
   logic [7:0]             dbyte;
   logic [CNT_W:0]         cw_sum, err_sum;
   logic [CNT_W-1:0]       cw_sat, err_sat;
   logic [RES_CNT_W-1:0]   n_v;

   logic                   run_fresh, run_closed;

   always_comb begin
      len6 = {1'b0, cfg.gen_len};
      if (len6 < 6'd2) begin
         len6 = 6'd2;
      end else if (len6 > GenMax6) begin
         len6 = GenMax6;
      end
      r6    = len6 - 6'd1;
      ridx  = r6[IdxW-1:0];
      dsize = cfg.dw_eight ? 4'd8 : 4'd4;
      cwlen = BicW'(r6 + 6'(dsize));
      gen48 = {32'd0, cfg.gen_bits};
      for (int k = 0; k < GEN_MAX_LEN; k++) begin
         lmask[k] = 6'(k) < len6;
      end
      for (int k = 0; k < RemW; k++) begin
         rmask[k] = 6'(k) < r6;
      end
      gmask = gen48[GEN_MAX_LEN-1:0] & lmask;
   end

   always_comb begin
      phase_in     = phase_ff;
      skip_in      = skip_ff;
      bic_in       = bic_ff;
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      acc_in       = acc_ff;
      fill_in      = fill_ff;
      ncw          = 2'd0;
      nerr         = 2'd0;
      dv           = 1'b0;
      dbyte        = 8'd0;
      bit_v        = 1'b0;
      t_v          = '0;
      comb16       = 16'd0;
      nfill        = 4'd0;

      if (phase_ff == PH_HEADER) begin
         skip_in  = in_byte[2:0];
         phase_in = PH_BODY;
      end else begin
         for (int b = BYTE_BITS - 1; b >= 0; b--) begin
            bit_v = in_byte[b];
            if (skip_in != 3'd0) begin
               skip_in = skip_in - 3'd1;
            end else begin
               if (bic_in < BicW'(dsize)) begin
                  pend_in = {pend_in[6:0], bit_v};
               end
               t_v = {rem_in, bit_v};
               if (t_v[ridx]) begin
                  t_v = t_v ^ gmask;
               end
               rem_in = t_v[RemW-1:0] & rmask;
               bic_in = bic_in + BicW'(1);
               if (bic_in >= cwlen) begin
                  // append the data bits, at most one byte fills per codeword
                  comb16 = cfg.dw_eight ? {acc_in, pend_in} : {4'd0, acc_in, pend_in[3:0]};
                  nfill  = {1'b0, fill_in} + dsize;
                  if (nfill >= 4'd8) begin
                     dv      = 1'b1;
                     dbyte   = 8'(comb16 >> (nfill - 4'd8));
                     fill_in = 3'(nfill - 4'd8);
                     acc_in  = comb16[7:0] & ~(8'hFF << fill_in);
                  end else begin
                     acc_in  = comb16[7:0];
                     fill_in = nfill[2:0];
                  end
                  ncw = ncw + 2'd1;
                  if (rem_in != '0) begin
                     nerr = nerr + 2'd1;
                  end
                  bic_in  = '0;
                  rem_in  = '0;
                  pend_in = 8'd0;
               end
            end
         end
      end

      cw_sum       = {1'b0, cw_total_ff} + (CNT_W + 1)'(ncw);
      err_sum      = {1'b0, err_total_ff} + (CNT_W + 1)'(nerr);
      cw_sat       = cw_sum[CNT_W] ? '1 : cw_sum[CNT_W-1:0];
      err_sat      = err_sum[CNT_W] ? '1 : err_sum[CNT_W-1:0];
      cw_total_in  = cw_sat;
      err_total_in = err_sat;

      res = '0;
      n_v = '0;
      if (dv) begin
         res[n_v] = '{kind: KIND_DATA, data: dbyte, cw_count: '0, err_count: '0, last: 1'b0};
         n_v      = n_v + RES_CNT_W'(1);
      end
      if (in_last) begin
         if (fill_in != 3'd0) begin
            res[n_v] = '{kind: KIND_DATA, data: acc_in, cw_count: '0, err_count: '0,
                         last: 1'b0};
            n_v      = n_v + RES_CNT_W'(1);
         end
         res[n_v] = '{kind: KIND_COUNTS, data: 8'd0, cw_count: cw_sat, err_count: err_sat,
                      last: 1'b1};
         n_v      = n_v + RES_CNT_W'(1);
         // run done, back to a fresh header
         phase_in     = PH_HEADER;
         skip_in      = 3'd0;
         bic_in       = '0;
         rem_in       = '0;
         pend_in      = 8'd0;
         acc_in       = 8'd0;
         fill_in      = 3'd0;
         cw_total_in  = '0;
         err_total_in = '0;
      end
      res_count = n_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         skip_ff      <= 3'd0;
         bic_ff       <= '0;
         rem_ff       <= '0;
         pend_ff      <= 8'd0;
         acc_ff       <= 8'd0;
         fill_ff      <= 3'd0;
         cw_total_ff  <= '0;
         err_total_ff <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         skip_ff      <= skip_in;
         bic_ff       <= bic_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         cw_total_ff  <= cw_total_in;
         err_total_ff <= err_total_in;
      end
   end

   assign run_fresh  = {bic_ff, rem_ff, fill_ff} == '0;
   assign run_closed = (phase_ff == PH_HEADER) && ({cw_total_ff, err_total_ff} == '0);

   `ASSERT_IMPL(a_fill_nibble, clock, reset, 1'b1, fill_ff[1:0] == 2'd0)
   `ASSERT_IMPL(a_header_clean, clock, reset, phase_ff == PH_HEADER, run_fresh)
   `ASSERT_NEXT(a_last_ends_run, clock, reset, advance && in_last, run_closed)

endmodule

// File: rtl/crc_codeword_checker.sv
// CRC codeword checker. Takes a coded file one byte per transfer on req_ch; the first byte
// of a run gives a padding count (low 3 bits), then the bit stream is cut into codewords of
// 4 or 8 data bits plus generator length minus one check bits, each divided by the generator
// set through csr_ch. Data bits come out as bytes on rsp_ch; the byte marked last also yields
// a right-aligned partial byte if any, then the codeword and error counts (out_last set).
// One byte is taken per cycle while the buffer is free; a byte that yields results holds
// the input while the three-entry result buffer drains, one result per cycle while rsp_ch is
// ready. The eight bit steps of a byte are combinational logic between the input stage and
// that buffer. Configuration writes are taken every cycle and apply to the next byte.
`include "assert_macros.svh"

module crc_codeword_checker import crcc_pkg::*; #(
   parameter int GEN_MAX_LEN = GEN_MAX_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   crcc_req_if.sink     req_ch,
   crcc_rsp_if.source   rsp_ch,
   crcc_csr_if.sink     csr_ch
);

   crcc_cfg_type         cfg_ff, cfg_in;

   logic                 stg_valid_ff, stg_valid_in;
   logic [BYTE_BITS-1:0] stg_byte_ff, stg_byte_in;
   logic                 stg_last_ff, stg_last_in;

   logic [RES_CNT_W-1:0] buf_n_ff, buf_n_in;
   logic [RES_CNT_W-1:0] buf_idx_ff, buf_idx_in;
   crcc_res_type         buf_ff [MAX_RES];
   crcc_res_type         rsp_sel;

   logic [RES_CNT_W-1:0]       res_count;
   crcc_res_type [MAX_RES-1:0] res;

   logic rsp_fire, buf_drain, buf_free, load, req_fire;

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_GEN_BITS: cfg_in.gen_bits = csr_ch.data;
            CSR_GEN_LEN:  cfg_in.gen_len  = csr_ch.data[GEN_LEN_W-1:0];
            CSR_DW_EIGHT: cfg_in.dw_eight = csr_ch.data[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gen_bits: GEN_BITS_RST, gen_len: GEN_LEN_RST, dw_eight: DW_EIGHT_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshakes
   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;
   assign buf_drain = rsp_fire && (buf_idx_ff == buf_n_ff - RES_CNT_W'(1));
   assign buf_free  = (buf_n_ff == '0) || buf_drain;
   assign load      = stg_valid_ff && buf_free;
   assign req_fire  = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !stg_valid_ff || load;

   crcc_engine #(
      .GEN_MAX_LEN (GEN_MAX_LEN)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .advance   (load),
      .in_byte   (stg_byte_ff),
      .in_last   (stg_last_ff),
      .res_count (res_count),
      .res       (res)
   );

   always_comb begin
      stg_valid_in = stg_valid_ff;
      stg_byte_in  = stg_byte_ff;
      stg_last_in  = stg_last_ff;
      if (req_fire) begin
         stg_valid_in = 1'b1;
         stg_byte_in  = req_ch.in_byte;
         stg_last_in  = req_ch.in_last;
      end else if (load) begin
         stg_valid_in = 1'b0;
      end

      buf_n_in   = buf_n_ff;
      buf_idx_in = buf_idx_ff;
      if (load) begin
         buf_n_in   = res_count;
         buf_idx_in = '0;
      end else if (buf_drain) begin
         buf_n_in   = '0;
         buf_idx_in = '0;
      end else if (rsp_fire) begin
         buf_idx_in = buf_idx_ff + RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         buf_n_ff     <= '0;
         buf_idx_ff   <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         buf_n_ff     <= buf_n_in;
         buf_idx_ff   <= buf_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_byte_ff <= stg_byte_in;
      stg_last_ff <= stg_last_in;
      if (load) begin
         for (int i = 0; i < MAX_RES; i++) begin
            buf_ff[i] <= res[i];
         end
      end
   end

   assign rsp_sel               = buf_ff[buf_idx_ff];
   assign rsp_ch.valid          = buf_n_ff != '0;
   assign rsp_ch.out_kind       = rsp_sel.kind;
   assign rsp_ch.out_byte       = rsp_sel.data;
   assign rsp_ch.codeword_count = rsp_sel.cw_count;
   assign rsp_ch.error_count    = rsp_sel.err_count;
   assign rsp_ch.out_last       = rsp_sel.last;

   `ASSERT_IMPL(a_idx_range, clock, reset, buf_n_ff != '0, buf_idx_ff < buf_n_ff)
   `ASSERT_IMPL(a_counts_close, clock, reset, rsp_ch.valid && rsp_ch.out_last, buf_idx_ff == buf_n_ff - RES_CNT_W'(1))
   `ASSERT_NEXT(a_stg_hold, clock, reset, stg_valid_ff && !load, stg_valid_ff && $stable(stg_byte_ff) && $stable(stg_last_ff))

endmodule
